### hw/rtl/rsa_crt_key_derivation_assert.svh
// assertion macros for the rsa crt key derivation block
`ifndef RSA_CRT_KEY_DERIVATION_ASSERT_SVH
`define RSA_CRT_KEY_DERIVATION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RCK_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsa_crt_key_derivation: assertion failed");

// next-cycle implication, checked out of reset
`define RCK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsa_crt_key_derivation: assertion failed");

`endif

### hw/rtl/rck_pkg.sv
// ----------------------------------------------------------------------------
// rck_pkg
// Shared types and constants of the rsa crt key derivation block.
// ----------------------------------------------------------------------------
package rck_pkg;

    // width of the wide datapath and divider, and of the divider bit counter
    localparam int WIDE_BITS = 64;
    localparam int CNT_W     = $clog2(WIDE_BITS);

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_EXP    = 2'd1;
    localparam logic [1:0] ST_NO_COEFF  = 2'd2;
    localparam logic [1:0] ST_DEGEN     = 2'd3;

    // datapath operation codes
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_MUL_N    = 4'd2;
    localparam logic [3:0] OP_MUL_PHI  = 4'd3;
    localparam logic [3:0] OP_LD_EM    = 4'd4;
    localparam logic [3:0] OP_LD_QP    = 4'd5;
    localparam logic [3:0] OP_LD_STEP  = 4'd6;
    localparam logic [3:0] OP_LD_DP    = 4'd7;
    localparam logic [3:0] OP_LD_DQ    = 4'd8;
    localparam logic [3:0] OP_DIV_ITER = 4'd9;
    localparam logic [3:0] OP_INIT_FIN = 4'd10;
    localparam logic [3:0] OP_STEP_FIN = 4'd11;
    localparam logic [3:0] OP_RP_FIN   = 4'd12;
    localparam logic [3:0] OP_RQ_FIN   = 4'd13;
    localparam logic [3:0] OP_D_FIN    = 4'd14;
    localparam logic [3:0] OP_C_FIN    = 4'd15;

    // command from controller to datapath
    typedef struct packed {
        logic [3:0] op;
    } rck_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic degen;
        logic r1_zero;
    } rck_sts_t;

endpackage

### hw/rtl/rck_datapath.sv
// ----------------------------------------------------------------------------
// rck_datapath
// Operand registers, shared 32x32 multiplier and a radix-2 restoring divider
// that also forms quotient times the Bezout coefficient, one bit a cycle.
// ----------------------------------------------------------------------------
module rck_datapath
    import rck_pkg::*;
#(
    parameter int PRIME_BITS = 32
)
(
    input  logic                 clk,
    input  rck_cmd_t             cmd,
    input  logic [31:0]          prime_p,
    input  logic [31:0]          prime_q,
    input  logic [63:0]          public_exp,
    output rck_sts_t             sts,
    output logic [63:0]          modulus,
    output logic [63:0]          private_exp,
    output logic [31:0]          exp_mod_p,
    output logic [31:0]          exp_mod_q,
    output logic [31:0]          crt_coeff,
    output logic [1:0]           status
);

    logic [PRIME_BITS-1:0]   p_reg;
    logic [PRIME_BITS-1:0]   q_reg;
    logic [WIDE_BITS-1:0]    e_reg;
    logic [WIDE_BITS-1:0]    n_reg;
    logic [WIDE_BITS-1:0]    m_reg;
    logic [WIDE_BITS-1:0]    r0_reg;
    logic [WIDE_BITS-1:0]    r1_reg;
    logic [WIDE_BITS-1:0]    u0_reg;
    logic [WIDE_BITS-1:0]    u1_reg;
    logic                    neg_reg;
    logic [WIDE_BITS-1:0]    dvd_reg;
    logic [WIDE_BITS-1:0]    dvs_reg;
    logic [WIDE_BITS-1:0]    rem_reg;
    logic [WIDE_BITS-1:0]    acc_reg;
    logic [WIDE_BITS-1:0]    d_reg;
    logic [WIDE_BITS-1:0]    dp_reg;
    logic [WIDE_BITS-1:0]    dq_reg;
    logic [WIDE_BITS-1:0]    coeff_reg;
    logic                    okd_reg;
    logic                    okc_reg;

    logic [PRIME_BITS-1:0]   pm1;
    logic [PRIME_BITS-1:0]   qm1;
    logic [PRIME_BITS-1:0]   mul_a;
    logic [PRIME_BITS-1:0]   mul_b;
    logic [2*PRIME_BITS-1:0] prod;
    logic [WIDE_BITS:0]      rem_sh;
    logic [WIDE_BITS:0]      diff;
    logic                    qbit;
    logic [WIDE_BITS-1:0]    rem_new;
    logic [WIDE_BITS-1:0]    acc_new;
    logic [WIDE_BITS-1:0]    inv_res;
    logic                    inv_ok;
    logic                    degen;

    // shared multiplier for n and phi
    always_comb
    begin
        pm1   = p_reg - PRIME_BITS'(1);
        qm1   = q_reg - PRIME_BITS'(1);
        mul_a = (cmd.op == OP_MUL_PHI) ? pm1 : p_reg;
        mul_b = (cmd.op == OP_MUL_PHI) ? qm1 : q_reg;
        prod  = mul_a * mul_b;
    end

    // one restoring division step with quotient times u1 accumulated
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[WIDE_BITS-1]};
        diff    = rem_sh - {1'b0, dvs_reg};
        qbit    = !diff[WIDE_BITS];
        rem_new = qbit ? diff[WIDE_BITS-1:0] : rem_sh[WIDE_BITS-1:0];
        acc_new = {acc_reg[WIDE_BITS-2:0], 1'b0} + (qbit ? u1_reg : '0);
    end

    // inverse from the final bezout coefficient
    always_comb
    begin
        inv_res = (neg_reg && (u0_reg != '0)) ? (m_reg - u0_reg) : u0_reg;
        inv_ok  = (r0_reg <= WIDE_BITS'(1));
        degen   = (p_reg < PRIME_BITS'(2)) || (q_reg < PRIME_BITS'(2));
    end

    // operation register file
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                p_reg     <= prime_p[PRIME_BITS-1:0];
                q_reg     <= prime_q[PRIME_BITS-1:0];
                e_reg     <= public_exp;
                d_reg     <= '0;
                dp_reg    <= '0;
                dq_reg    <= '0;
                coeff_reg <= '0;
                okd_reg   <= 1'b1;
                okc_reg   <= 1'b1;
            end
            OP_MUL_N:   n_reg <= WIDE_BITS'(prod);
            OP_MUL_PHI: m_reg <= WIDE_BITS'(prod);
            OP_LD_EM:
            begin
                dvd_reg <= e_reg;
                dvs_reg <= m_reg;
                rem_reg <= '0;
                acc_reg <= '0;
            end
            OP_LD_QP:
            begin
                m_reg   <= WIDE_BITS'(p_reg);
                dvd_reg <= WIDE_BITS'(q_reg);
                dvs_reg <= WIDE_BITS'(p_reg);
                rem_reg <= '0;
                acc_reg <= '0;
            end
            OP_LD_STEP:
            begin
                dvd_reg <= r0_reg;
                dvs_reg <= r1_reg;
                rem_reg <= '0;
                acc_reg <= '0;
            end
            OP_LD_DP:
            begin
                dvd_reg <= d_reg;
                dvs_reg <= WIDE_BITS'(pm1);
                rem_reg <= '0;
                acc_reg <= '0;
            end
            OP_LD_DQ:
            begin
                dvd_reg <= d_reg;
                dvs_reg <= WIDE_BITS'(qm1);
                rem_reg <= '0;
                acc_reg <= '0;
            end
            OP_DIV_ITER:
            begin
                dvd_reg <= {dvd_reg[WIDE_BITS-2:0], 1'b0};
                rem_reg <= rem_new;
                acc_reg <= acc_new;
            end
            OP_INIT_FIN:
            begin
                r0_reg  <= m_reg;
                r1_reg  <= rem_reg;
                u0_reg  <= '0;
                u1_reg  <= WIDE_BITS'(1);
                neg_reg <= 1'b1;
            end
            OP_STEP_FIN:
            begin
                r0_reg  <= r1_reg;
                r1_reg  <= rem_reg;
                u0_reg  <= u1_reg;
                u1_reg  <= acc_reg + u0_reg;
                neg_reg <= !neg_reg;
            end
            OP_RP_FIN: dp_reg <= rem_reg;
            OP_RQ_FIN: dq_reg <= rem_reg;
            OP_D_FIN:
            begin
                d_reg   <= inv_ok ? inv_res : '0;
                okd_reg <= inv_ok;
            end
            OP_C_FIN:
            begin
                coeff_reg <= inv_ok ? inv_res : '0;
                okc_reg   <= inv_ok;
            end
            default:
            begin
            end
        endcase
    end

    // status towards the controller
    assign sts.degen   = degen;
    assign sts.r1_zero = (r1_reg == '0);

    // result fields
    assign modulus     = n_reg;
    assign private_exp = d_reg;
    assign exp_mod_p   = dp_reg[31:0];
    assign exp_mod_q   = dq_reg[31:0];
    assign crt_coeff   = coeff_reg[31:0];

    always_comb
    begin
        priority if (degen)
            status = ST_DEGEN;
        else if (!okd_reg)
            status = ST_NO_EXP;
        else if (!okc_reg)
            status = ST_NO_COEFF;
        else
            status = ST_OK;
    end

endmodule

### hw/rtl/rck_ctrl.sv
// ----------------------------------------------------------------------------
// rck_ctrl
// Sequencer for the two extended euclid runs, the two reductions and the
// divider bit count.
// ----------------------------------------------------------------------------
module rck_ctrl
    import rck_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  rck_sts_t sts,
    output rck_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULN  = 4'd1;
    localparam logic [3:0] S_PHI   = 4'd2;
    localparam logic [3:0] S_LD_D  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_TEST  = 4'd6;
    localparam logic [3:0] S_LD_C  = 4'd7;
    localparam logic [3:0] S_LD_DP = 4'd8;
    localparam logic [3:0] S_LD_DQ = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    localparam logic [1:0] K_INIT  = 2'd0;
    localparam logic [1:0] K_STEP  = 2'd1;
    localparam logic [1:0] K_RED_P = 2'd2;
    localparam logic [1:0] K_RED_Q = 2'd3;

    localparam logic PH_D = 1'b0;
    localparam logic PH_C = 1'b1;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDE_BITS - 1);

    logic [3:0]       state_reg, state_next;
    logic [1:0]       kind_reg, kind_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MULN;
                end
            end
            S_MULN:
            begin
                cmd.op     = OP_MUL_N;
                state_next = sts.degen ? S_DONE : S_PHI;
            end
            S_PHI:
            begin
                cmd.op     = OP_MUL_PHI;
                state_next = S_LD_D;
            end
            S_LD_D:
            begin
                cmd.op     = OP_LD_EM;
                phase_next = PH_D;
                kind_next  = K_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV_ITER;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                unique case (kind_reg)
                    K_INIT:
                    begin
                        cmd.op     = OP_INIT_FIN;
                        state_next = S_TEST;
                    end
                    K_STEP:
                    begin
                        cmd.op     = OP_STEP_FIN;
                        state_next = S_TEST;
                    end
                    K_RED_P:
                    begin
                        cmd.op     = OP_RP_FIN;
                        state_next = S_LD_DQ;
                    end
                    default:
                    begin
                        cmd.op     = OP_RQ_FIN;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TEST:
            begin
                if (sts.r1_zero)
                begin
                    if (phase_reg == PH_D)
                    begin
                        cmd.op     = OP_D_FIN;
                        state_next = S_LD_C;
                    end
                    else
                    begin
                        cmd.op     = OP_C_FIN;
                        state_next = S_LD_DP;
                    end
                end
                else
                begin
                    cmd.op     = OP_LD_STEP;
                    kind_next  = K_STEP;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_LD_C:
            begin
                cmd.op     = OP_LD_QP;
                phase_next = PH_C;
                kind_next  = K_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_LD_DP:
            begin
                cmd.op     = OP_LD_DP;
                kind_next  = K_RED_P;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_LD_DQ:
            begin
                cmd.op     = OP_LD_DQ;
                kind_next  = K_RED_Q;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= K_INIT;
            phase_reg <= PH_D;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### hw/rtl/rsa_crt_key_derivation.sv
// ----------------------------------------------------------------------------
// rsa_crt_key_derivation
// RSA CRT private key derivation from two primes and a public exponent.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low; it carries
// prime_p, prime_q and public_exp. busy stays high while the key is worked
// out. The result (modulus, private_exp, exp_mod_p, exp_mod_q, crt_coeff,
// status) is shown for one cycle with done high, and the fields hold their
// value until the next request is taken. The receiver cannot stall.
// A degenerate prime ends the run right after the modulus product. Otherwise
// each extended euclid step costs one pass of the shared restoring divider
// plus the update of remainders and coefficients, and the two reductions
// cost one divider pass each. The divider, one quotient bit a cycle,
// dominates the run time. busy drops in the cycle done is high, so a new
// request may be taken then. Reset returns the sequencer to idle with done
// low; no state carries between requests.
// ----------------------------------------------------------------------------
`include "rsa_crt_key_derivation_assert.svh"

module rsa_crt_key_derivation
    import rck_pkg::*;
#(
    parameter int PRIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] prime_p,
    input  logic [31:0] prime_q,
    input  logic [63:0] public_exp,
    output logic        done,
    output logic [63:0] modulus,
    output logic [63:0] private_exp,
    output logic [31:0] exp_mod_p,
    output logic [31:0] exp_mod_q,
    output logic [31:0] crt_coeff,
    output logic [1:0]  status
);

    rck_cmd_t cmd;
    rck_sts_t sts;

    // sequencer
    rck_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // arithmetic
    rck_datapath #(
        .PRIME_BITS (PRIME_BITS)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .prime_p     (prime_p),
        .prime_q     (prime_q),
        .public_exp  (public_exp),
        .sts         (sts),
        .modulus     (modulus),
        .private_exp (private_exp),
        .exp_mod_p   (exp_mod_p),
        .exp_mod_q   (exp_mod_q),
        .crt_coeff   (crt_coeff),
        .status      (status)
    );

    // checks
    `RCK_ASSERT_NEXT(a_done_single, done, !done)
    `RCK_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `RCK_ASSERT_SAME(a_no_exp_zero, done && (status == ST_NO_EXP), private_exp == '0)
    `RCK_ASSERT_SAME(a_degen_zero, done && (status == ST_DEGEN), private_exp == '0)
    `RCK_ASSERT_SAME(a_exp_below_n, done && (status == ST_OK), private_exp < modulus)

endmodule

### sim/tb_rsa_crt_key_derivation.sv
// ----------------------------------------------------------------------------
// tb_rsa_crt_key_derivation
// Self-checking bench for the rsa crt key derivation block: directed corner
// keys, then random prime pairs and exponents, checked against a behavioural
// derivation of the key components.
// ----------------------------------------------------------------------------
module tb_rsa_crt_key_derivation;
    import rck_pkg::*;

    typedef struct packed {
        logic [31:0] p;
        logic [31:0] q;
        logic [63:0] e;
    } key_req_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] d;
        logic [31:0] dp;
        logic [31:0] dq;
        logic [31:0] coeff;
        logic [1:0]  st;
    } key_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] prime_p;
    logic [31:0] prime_q;
    logic [63:0] public_exp;
    logic        done;
    logic [63:0] modulus;
    logic [63:0] private_exp;
    logic [31:0] exp_mod_p;
    logic [31:0] exp_mod_q;
    logic [31:0] crt_coeff;
    logic [1:0]  status;

    key_req_t pending_reqs[$];
    key_res_t expected_keys[$];
    int       errors;
    int       idle_left;
    int       req_count;
    int       key_count;
    bit       no_idle;
    bit       drain_hold;
    bit       stim_done;

    rsa_crt_key_derivation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .prime_p(prime_p), .prime_q(prime_q), .public_exp(public_exp),
        .done(done), .modulus(modulus), .private_exp(private_exp),
        .exp_mod_p(exp_mod_p), .exp_mod_q(exp_mod_q),
        .crt_coeff(crt_coeff), .status(status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // modular inverse by extended euclid, magnitudes with alternating sign
    function automatic bit mod_inverse(input logic [63:0] x, input logic [63:0] m,
                                       output logic [63:0] inv);
        logic [63:0] r0, r1, u0, u1, quo, tmp;
        bit neg0;
        inv = '0;
        if (m == 0)
            return 1'b0;
        r0 = m;
        r1 = x % m;
        u0 = 0;
        u1 = 1;
        neg0 = 1'b1;
        while (r1 != 0)
        begin
            quo = r0 / r1;
            tmp = r0 - quo * r1;
            r0 = r1;
            r1 = tmp;
            tmp = u0 + quo * u1;
            u0 = u1;
            u1 = tmp;
            neg0 = !neg0;
        end
        if (r0 > 1)
            return 1'b0;
        inv = (neg0 && u0 != 0) ? m - u0 : u0;
        return 1'b1;
    endfunction

    // key components for one request
    function automatic key_res_t derive_key(input key_req_t r);
        key_res_t k;
        logic [63:0] p, q, d, c;
        bit ok_d, ok_c;
        p = {32'd0, r.p};
        q = {32'd0, r.q};
        k = '0;
        k.n = p * q;
        if (p < 2 || q < 2)
            k.st = ST_DEGEN;
        else
        begin
            ok_d = mod_inverse(r.e, (p - 1) * (q - 1), d);
            ok_c = mod_inverse(q, p, c);
            if (!ok_d) d = 0;
            if (!ok_c) c = 0;
            k.d = d;
            k.dp = 32'(d % (p - 1));
            k.dq = 32'(d % (q - 1));
            k.coeff = c[31:0];
            k.st = !ok_d ? ST_NO_EXP : (!ok_c ? ST_NO_COEFF : ST_OK);
        end
        return k;
    endfunction

    function automatic bit is_prime(input logic [31:0] v);
        logic [31:0] i;
        if (v < 2) return 1'b0;
        for (i = 2; i * i <= v && i < 65536; i++)
            if (v % i == 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_prime(input int bits);
        logic [31:0] v;
        v = $urandom;
        if (bits < 32) v = v & ((32'd1 << bits) - 1);
        v = v | (32'd1 << (bits - 1)) | 32'd1;
        while (!is_prime(v)) v = v + 2;
        return v;
    endfunction

    // driver: one request at a time, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            prime_p <= '0;
            prime_q <= '0;
            public_exp <= '0;
            idle_left <= 0;
        end
        else if (start && !busy)
        begin
            start <= 1'b0;
            expected_keys.push_back(derive_key({prime_p, prime_q, public_exp}));
            req_count <= req_count + 1;
            if (!no_idle && $urandom_range(0, 2) == 0)
                idle_left <= $urandom_range(1, 14);
        end
        else if (!start)
        begin
            if (idle_left > 0)
                idle_left <= idle_left - 1;
            else if (drain_hold && expected_keys.size() != 0)
                ;
            else if (pending_reqs.size() != 0)
            begin
                key_req_t r;
                r = pending_reqs.pop_front();
                start <= 1'b1;
                prime_p <= r.p;
                prime_q <= r.q;
                public_exp <= r.e;
                if (drain_hold) drain_hold <= 1'b0;
            end
        end
    end

    // monitor: check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_keys.size() == 0)
            begin
                errors <= errors + 1;
                $display("%0t: unexpected result, expected none, actual n=%h", $time, modulus);
            end
            else
            begin
                key_res_t x;
                x = expected_keys.pop_front();
                key_count <= key_count + 1;
                if (x != {modulus, private_exp, exp_mod_p, exp_mod_q, crt_coeff, status})
                begin
                    errors <= errors + 1;
                    $display("%0t: mismatch p=%h q=%h", $time, prime_p, prime_q);
                    $display("  expected n=%h d=%h dp=%h dq=%h c=%h st=%0d",
                             x.n, x.d, x.dp, x.dq, x.coeff, x.st);
                    $display("  actual   n=%h d=%h dp=%h dq=%h c=%h st=%0d",
                             modulus, private_exp, exp_mod_p, exp_mod_q,
                             crt_coeff, status);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        key_req_t r;
        int i;
        errors = 0; req_count = 0; key_count = 0;
        no_idle = 0; drain_hold = 0; stim_done = 0;
        start = 0; prime_p = 0; prime_q = 0; public_exp = 0; idle_left = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: degenerate primes, unit modulus, zero exponent, extremes
        pending_reqs.push_back('{32'd0, 32'd0, 64'd0});
        pending_reqs.push_back('{32'd1, 32'd7, 64'd3});
        pending_reqs.push_back('{32'd11, 32'd1, 64'd3});
        pending_reqs.push_back('{32'hffffffff, 32'd0, 64'hffffffffffffffff});
        pending_reqs.push_back('{32'd2, 32'd2, 64'd5});
        pending_reqs.push_back('{32'd2, 32'd2, 64'd0});
        pending_reqs.push_back('{32'd61, 32'd53, 64'd17});
        pending_reqs.push_back('{32'd61, 32'd53, 64'd0});
        pending_reqs.push_back('{32'd61, 32'd53, 64'd6});
        pending_reqs.push_back('{32'd61, 32'd61, 64'd7});
        pending_reqs.push_back('{32'd15, 32'd25, 64'd7});
        pending_reqs.push_back('{32'd4, 32'd6, 64'd7});
        pending_reqs.push_back('{32'hfffffffb, 32'hffffffef, 64'd65537});
        pending_reqs.push_back('{32'hfffffffb, 32'hffffffef, 64'hffffffffffffffff});
        pending_reqs.push_back('{32'hffffffff, 32'hffffffff, 64'h8000000000000001});
        pending_reqs.push_back('{32'hffffffff, 32'hfffffffe, 64'd1});
        pending_reqs.push_back('{32'd3, 32'hfffffffb, 64'd65537});
        pending_reqs.push_back('{32'd2, 32'd3, 64'd1});
        pending_reqs.push_back('{32'd7, 32'd7, 64'd5});

        // random: mostly genuine primes, some arbitrary values
        for (i = 0; i < 100; i++)
        begin
            int bits;
            bits = ($urandom_range(0, 5) == 0) ? 32 : $urandom_range(2, 20);
            case ($urandom_range(0, 9))
                0: r = '{$urandom, $urandom, {$urandom, $urandom}};
                1: r = '{$urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 99)};
                default:
                begin
                    r.p = rand_prime(bits);
                    r.q = rand_prime($urandom_range(2, bits));
                    case ($urandom_range(0, 3))
                        0: r.e = 64'd65537;
                        1: r.e = $urandom_range(0, 1000);
                        default: r.e = {$urandom, $urandom};
                    endcase
                end
            endcase
            pending_reqs.push_back(r);
            if (i == 40)
            begin
                wait (pending_reqs.size() == 0);
                drain_hold = 1;
            end
        end
        wait (pending_reqs.size() < 15);
        no_idle = 1;
        wait (pending_reqs.size() == 0 && !start);
        wait (expected_keys.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d requests and checked %0d key results,", req_count, key_count);
        $display("including degenerate, non-invertible and full-width keys");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit: room for ~120 requests, several times over
    initial
    begin
        #(8 * 5000000);
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
